// File: rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg - shared constants for the primitive root search
// Default widths and sizes, and the port widths fixed by the interface.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  // default modulus width used by the search datapath
  localparam int unsigned MOD_BITS_DEF    = 32;
  // default depth of the factor store
  localparam int unsigned MAX_FACTORS_DEF = 16;
  // fixed port widths
  localparam int unsigned IN_W            = 32;
  localparam int unsigned ROOT_W          = 32;
  // smallest modulus that has a candidate
  localparam int unsigned MIN_MODULUS     = 3;
  // first candidate and first trial divisor
  localparam int unsigned FIRST_CAND      = 2;

endpackage

`default_nettype wire

// File: rtl/primitive_root_search.sv
// ----------------------------------------------------------------------------
// primitive_root_search - smallest primitive root modulo a prime
// Factors p-1 by trial division, then tests g = 2, 3, ... with bit-serial
// modular exponentiation until every factor power differs from one.
// ----------------------------------------------------------------------------
// Usage: pulse start while busy is low to transfer a modulus; for a modulus of
// three or more, busy stays high until the answer. done is high for exactly one
// cycle and marks the answer on root/found. The receiver cannot stall, so sample
// done every cycle. One item is in flight at a time. Timing is data dependent:
// trial division costs about sqrt(p) divisor steps on the one-bit-per-cycle
// restoring divider; each candidate then costs, per factor, one division plus
// up to 2*MOD_BITS modular products from the double-and-add multiplier. A
// modulus below three answers in the cycle right after its transfer.
`default_nettype none

module primitive_root_search
  import prs_pkg::*;
#(
  parameter int unsigned MOD_BITS    = MOD_BITS_DEF,
  parameter int unsigned MAX_FACTORS = MAX_FACTORS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [IN_W-1:0]   modulus,
  output logic              done,
  output logic [ROOT_W-1:0] root,
  output logic              found
);

  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned CW = $clog2(MAX_FACTORS + 1);
  localparam int unsigned IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int unsigned KW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TD_CHECK, S_TD_DIV, S_G_CHECK, S_F_CHECK, S_F_READ,
    S_F_DIV, S_P_STEP, S_P_MR, S_P_MB
  } state_t;

  state_t          state;
  logic [W-1:0]    p, phi, rest, d, g;
  logic [W+1:0]    dsq;
  logic            took;
  logic [CW-1:0]   count, fi;
  // shared divider
  logic [W-1:0]    dq, drem, dvs;
  logic [KW-1:0]   dcnt;
  // shared modular multiplier
  logic [W-1:0]    ma, mb, acc;
  // exponentiation
  logic [W-1:0]    ex, pr, base;
  // factor store
  logic [W-1:0]    mem [MAX_FACTORS];
  logic [W-1:0]    q_rd;
  logic            store_en;
  logic [W-1:0]    store_val;

  logic [W-1:0]    p_in;
  logic [W:0]      trial, acc_sum, a_dbl;
  logic            trial_ge;
  logic            dsq_le;
  logic [W-1:0]    acc_next, ma_next;
  logic [63:0]     g_wide;

  assign p_in     = W'(modulus);
  assign busy     = (state != S_IDLE);
  assign g_wide   = 64'(g);

  // divider step: shift in next dividend bit, subtract when it fits
  assign trial    = {drem, dq[W-1]};
  assign trial_ge = (trial >= {1'b0, dvs});

  // multiplier step: conditional add and doubling, both reduced mod p
  assign acc_sum  = {1'b0, acc} + {1'b0, ma};
  assign acc_next = (acc_sum >= {1'b0, p}) ? W'(acc_sum - {1'b0, p}) : acc_sum[W-1:0];
  assign a_dbl    = {ma, 1'b0};
  assign ma_next  = (a_dbl >= {1'b0, p}) ? W'(a_dbl - {1'b0, p}) : a_dbl[W-1:0];

  assign dsq_le   = (dsq <= (W+2)'(rest));

  // new factor capture
  always_comb begin
    store_en  = 1'b0;
    store_val = d;
    if (state == S_TD_CHECK && !dsq_le && rest > W'(1)) begin
      store_en  = 1'b1;
      store_val = rest;
    end else if (state == S_TD_DIV && dcnt == '0 && drem == '0 && !took) begin
      store_en  = 1'b1;
    end
    if (count >= CW'(MAX_FACTORS)) store_en = 1'b0;
  end

  // factor store, registered read
  always_ff @(posedge clk) begin
    if (store_en) mem[count[IW-1:0]] <= store_val;
    q_rd <= mem[fi[IW-1:0]];
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (store_en) count <= count + CW'(1);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            p <= p_in;
            if (p_in < W'(MIN_MODULUS)) begin
              count <= '0;
              done  <= 1'b1;
              found <= 1'b0;
              root  <= '0;
            end else begin
              phi   <= p_in - W'(1);
              rest  <= p_in - W'(1);
              d     <= W'(FIRST_CAND);
              dsq   <= (W+2)'(FIRST_CAND * FIRST_CAND);
              took  <= 1'b0;
              count <= '0;
              state <= S_TD_CHECK;
            end
          end
        end
        // trial divisor loop bound
        S_TD_CHECK: begin
          if (dsq_le) begin
            dq    <= rest;
            dvs   <= d;
            drem  <= '0;
            dcnt  <= KW'(W);
            state <= S_TD_DIV;
          end else begin
            g     <= W'(FIRST_CAND);
            state <= S_G_CHECK;
          end
        end
        // rest / d, then divide out repeatedly
        S_TD_DIV: begin
          if (dcnt != '0) begin
            dq   <= {dq[W-2:0], trial_ge};
            drem <= trial_ge ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
            dcnt <= dcnt - KW'(1);
          end else if (drem == '0) begin
            took <= 1'b1;
            rest <= dq;
            dq   <= dq;
            drem <= '0;
            dcnt <= KW'(W);
          end else begin
            took  <= 1'b0;
            dsq   <= dsq + (W+2)'({d, 1'b1});
            d     <= d + W'(1);
            state <= S_TD_CHECK;
          end
        end
        // next candidate
        S_G_CHECK: begin
          if (g >= p) begin
            done  <= 1'b1;
            found <= 1'b0;
            root  <= '0;
            state <= S_IDLE;
          end else begin
            fi    <= '0;
            state <= S_F_CHECK;
          end
        end
        S_F_CHECK: begin
          if (fi >= count) begin
            done  <= 1'b1;
            found <= 1'b1;
            root  <= g_wide[ROOT_W-1:0];
            state <= S_IDLE;
          end else begin
            state <= S_F_READ;
          end
        end
        // factor word is valid now
        S_F_READ: begin
          if (q_rd == '0) begin
            g     <= g + W'(1);
            state <= S_G_CHECK;
          end else begin
            dq    <= phi;
            dvs   <= q_rd;
            drem  <= '0;
            dcnt  <= KW'(W);
            state <= S_F_DIV;
          end
        end
        S_F_DIV: begin
          if (dcnt != '0) begin
            dq   <= {dq[W-2:0], trial_ge};
            drem <= trial_ge ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
            dcnt <= dcnt - KW'(1);
          end else begin
            ex    <= dq;
            pr    <= W'(1);
            base  <= g;
            state <= S_P_STEP;
          end
        end
        // square-and-multiply sequencing
        S_P_STEP: begin
          if (ex == '0) begin
            if (pr == W'(1)) begin
              g     <= g + W'(1);
              state <= S_G_CHECK;
            end else begin
              fi    <= fi + CW'(1);
              state <= S_F_CHECK;
            end
          end else if (ex[0]) begin
            ma    <= pr;
            mb    <= base;
            acc   <= '0;
            state <= S_P_MR;
          end else begin
            ma    <= base;
            mb    <= base;
            acc   <= '0;
            state <= S_P_MB;
          end
        end
        S_P_MR: begin
          if (mb != '0) begin
            if (mb[0]) acc <= acc_next;
            ma <= ma_next;
            mb <= mb >> 1;
          end else begin
            pr    <= acc;
            ma    <= base;
            mb    <= base;
            acc   <= '0;
            state <= S_P_MB;
          end
        end
        S_P_MB: begin
          if (mb != '0) begin
            if (mb[0]) acc <= acc_next;
            ma <= ma_next;
            mb <= mb >> 1;
          end else begin
            base  <= acc;
            ex    <= ex >> 1;
            state <= S_P_STEP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only ends a search that was running or a tiny modulus just taken
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("done without a running search");
  // a transfer of a modulus of three or more starts the search
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && p_in >= W'(MIN_MODULUS)) |=> busy)
    else $error("accepted modulus did not start a search");
  // a reported root is at least two
  a_root: assert property (@(posedge clk) disable iff (rst) (done && found) |-> (g >= W'(2)))
    else $error("root below two reported");
  // store never overfills
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_FACTORS))
    else $error("factor count overflow");

endmodule

`default_nettype wire

// File: bench/tb_primitive_root_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_primitive_root_search - self-checking bench for the primitive root search
// A directed table (tiny moduli, small primes, composites, wide moduli) and
// then cost-bounded random moduli are sent with random gaps. Every answer is
// compared with a typed table value or an in-bench search for the smallest primitive root.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_primitive_root_search;
  import prs_pkg::*;

  localparam int unsigned NUM_RANDOM = 85;
  localparam int unsigned STALL_LIMIT = 4000000;
  // cycle estimates per divisor step and per exponentiation in the block
  localparam longint unsigned DIV_STEP_CYC = 34;
  localparam longint unsigned POW_CYC = 2150;
  localparam longint unsigned RAND_COST_MAX = 200000;

  typedef struct {
    logic [ROOT_W-1:0] root;
    logic found;
  } root_answer_t;

  typedef struct {
    logic [IN_W-1:0] modulus;
    bit typed;
    logic [ROOT_W-1:0] root;
    logic found;
  } table_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [IN_W-1:0] modulus;
  logic done;
  logic [ROOT_W-1:0] root;
  logic found;

  root_answer_t answers_pending[$];
  int unsigned mismatches;
  int unsigned answers_checked;
  int unsigned moduli_sent;
  int unsigned idle_cycles;

  primitive_root_search u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .modulus(modulus),
    .done(done),
    .root(root),
    .found(found)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // smallest primitive root search, with a rough cycle cost of the block
  function automatic void search_root(input logic [IN_W-1:0] m,
                                      output root_answer_t ans,
                                      output longint unsigned cost);
    longint unsigned p, phi, rest, d, g, b, e, acc;
    longint unsigned facs[$];
    bit ok;
    ans.root = '0;
    ans.found = 1'b0;
    cost = 2;
    p = m;
    if (p < MIN_MODULUS) return;
    phi = p - 1;
    rest = phi;
    // trial division, distinct factors only
    for (d = FIRST_CAND; d * d <= rest; d++) begin
      cost += DIV_STEP_CYC;
      if (rest % d == 0) begin
        if (facs.size() < MAX_FACTORS_DEF) facs.push_back(d);
        while (rest % d == 0) rest = rest / d;
      end
    end
    if (rest > 1 && facs.size() < MAX_FACTORS_DEF) facs.push_back(rest);
    // candidate scan
    for (g = FIRST_CAND; g < p; g++) begin
      ok = 1'b1;
      foreach (facs[i]) begin
        cost += POW_CYC;
        acc = 1 % p;
        b = g % p;
        e = phi / facs[i];
        while (e != 0) begin
          if (e[0]) acc = (acc * b) % p;
          b = (b * b) % p;
          e = e >> 1;
        end
        if (acc == 1) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) begin
        ans.root = g[ROOT_W-1:0];
        ans.found = 1'b1;
        return;
      end
    end
  endfunction

  // one modulus: random gap with start low, then hold start until the transfer
  task automatic send_modulus(input logic [IN_W-1:0] m, input root_answer_t ans);
    int unsigned gap;
    gap = $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      modulus <= $urandom;
    end
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    modulus <= m;
    do @(posedge clk); while (busy);
    answers_pending.push_back(ans);
    moduli_sent++;
  endtask

  // answer checker
  always @(posedge clk) begin
    root_answer_t want;
    if (!rst && done) begin
      if (answers_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected answer root=%0d found=%0b", $realtime, root, found);
      end else begin
        want = answers_pending.pop_front();
        answers_checked++;
        if (root !== want.root || found !== want.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected root=%0d found=%0b, got root=%0d found=%0b",
                     $realtime, want.root, want.found, root, found);
        end
      end
    end
  end

  // watchdog on cycles without any transfer or answer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    table_row_t rows[$];
    root_answer_t ans;
    longint unsigned cost;
    logic [IN_W-1:0] m;
    int unsigned shape;
    mismatches = 0;
    answers_checked = 0;
    moduli_sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    modulus <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: below three, small primes, composites, wide moduli
    rows = '{
      '{32'd0, 1'b1, 32'd0, 1'b0},
      '{32'd1, 1'b1, 32'd0, 1'b0},
      '{32'd2, 1'b1, 32'd0, 1'b0},
      '{32'd3, 1'b1, 32'd2, 1'b1},
      '{32'd5, 1'b1, 32'd2, 1'b1},
      '{32'd7, 1'b1, 32'd3, 1'b1},
      '{32'd4, 1'b0, 32'd0, 1'b0},
      '{32'd9, 1'b0, 32'd0, 1'b0},
      '{32'd15, 1'b0, 32'd0, 1'b0},
      '{32'd41, 1'b0, 32'd0, 1'b0},
      '{32'd4093, 1'b0, 32'd0, 1'b0},
      '{32'd65537, 1'b0, 32'd0, 1'b0},
      '{32'h8000_0001, 1'b0, 32'd0, 1'b0},
      '{32'hC000_0001, 1'b0, 32'd0, 1'b0},
      '{32'hFFFF_FFFB, 1'b0, 32'd0, 1'b0}
    };
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        ans.root = rows[i].root;
        ans.found = rows[i].found;
      end else begin
        search_root(rows[i].modulus, ans, cost);
      end
      send_modulus(rows[i].modulus, ans);
    end

    // random: mostly small moduli, some wide ones whose p-1 is mostly twos
    for (int n = 0; n < NUM_RANDOM; n++) begin
      do begin
        shape = $urandom_range(0, 99);
        if (shape < 60) m = $urandom_range(3, 4095);
        else if (shape < 75) m = $urandom_range(0, 65535);
        else if (shape < 82) m = $urandom_range(0, 2);
        else m = ((IN_W'($urandom) & 32'hFFF) << $urandom_range(12, 20)) | 32'd1;
        search_root(m, ans, cost);
      end while (cost > RAND_COST_MAX);
      send_modulus(m, ans);
    end
    start <= 1'b0;

    while (answers_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d moduli (tiny, prime, composite, up to 32 bits); %0d answers checked.",
             moduli_sent, answers_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
